// ===== rtl/core/eihc_pkg.sv =====
// ---------------------------------------------------------------------------
// eihc_pkg: shared types and constants for the IPv4 header checker
// Byte-lane transaction types, per-frame summary, verdict codes.
// ---------------------------------------------------------------------------
package eihc_pkg;

   localparam int LEN_BITS       = 16;
   localparam int CMP_BITS       = (LEN_BITS > 16) ? LEN_BITS : 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [3:0]  IP_VERSION  = 4'd4;
   localparam logic [3:0]  MIN_IHL     = 4'd5;
   localparam logic [4:0]  ETH_HDR     = 5'd14;
   localparam logic [4:0]  VLAN_HDR    = 5'd18;
   localparam logic [4:0]  ETHTYPE_HI  = 5'd12;
   localparam logic [4:0]  ETHTYPE_LO  = 5'd13;
   localparam logic [4:0]  INNER_HI    = 5'd16;
   localparam logic [4:0]  INNER_LO    = 5'd17;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_WIRE_MISMATCH = 3'd1,
      ST_NOT_IPV4      = 3'd2,
      ST_BAD_VERSION   = 3'd3,
      ST_HDR_BEYOND    = 3'd4,
      ST_TOTAL_BEYOND  = 3'd5,
      ST_TRUNCATED     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      L4_OTHER     = 3'd0,
      L4_TCP       = 3'd1,
      L4_UDP_OK    = 3'd2,
      L4_UDP_BIG   = 3'd3,
      L4_UDP_TRUNC = 3'd4
   } l4_kind_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] wire_len;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  ip_offset;
      logic [5:0]  ip_header_len;
      logic [15:0] ip_total_len;
      l4_kind_type l4_kind;
      logic [6:0]  l4_offset;
      logic [15:0] captured_len;
   } rsp_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] cap;
      logic [15:0]         wire_len;
      logic [15:0]         ether_kind;
      logic [15:0]         inner_kind;
      logic [7:0]          version_ihl;
      logic [15:0]         total_length;
      logic [7:0]          protocol_byte;
      logic [15:0]         udp_length;
   } summary_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

endpackage

// ===== rtl/core/eihc_front.sv =====
// ---------------------------------------------------------------------------
// eihc_front: byte parser
// Counts captured bytes, picks header fields, pushes a summary per frame.
// ---------------------------------------------------------------------------
module eihc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  eihc_pkg::req_type        req_data,
   input  eihc_pkg::queue_status_type q_status,
   output logic                     req_stall,
   output logic                     push,
   output eihc_pkg::summary_type    push_data
);

   logic [eihc_pkg::LEN_BITS-1:0] count_ff, count_in;
   logic [15:0] ether_ff, ether_in;
   logic        tagged_ff, tagged_in;
   logic [15:0] inner_ff, inner_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] udp_ff, udp_in;

   logic        accept;
   logic [eihc_pkg::LEN_BITS-1:0] idx;
   logic [eihc_pkg::LEN_BITS-1:0] base;
   logic [eihc_pkg::LEN_BITS-1:0] l4;
   logic [7:0]  d;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign d         = req_data.data_byte;

   always_comb begin
      count_in  = count_ff;
      ether_in  = ether_ff;
      tagged_in = tagged_ff;
      inner_in  = inner_ff;
      vihl_in   = vihl_ff;
      total_in  = total_ff;
      proto_in  = proto_ff;
      udp_in    = udp_ff;
      if (req_data.first_byte) begin
         count_in  = '0;
         ether_in  = '0;
         tagged_in = 1'b0;
         inner_in  = '0;
         vihl_in   = '0;
         total_in  = '0;
         proto_in  = '0;
         udp_in    = '0;
      end
      idx = count_in;
      if (count_in != eihc_pkg::LEN_MAX) begin
         count_in = count_in + 1'b1;
      end
      if (idx == eihc_pkg::LEN_BITS'(eihc_pkg::ETHTYPE_HI)) begin
         ether_in = {d, ether_in[7:0]};
      end
      if (idx == eihc_pkg::LEN_BITS'(eihc_pkg::ETHTYPE_LO)) begin
         ether_in  = {ether_in[15:8], d};
         tagged_in = (ether_in == eihc_pkg::ETYPE_VLAN);
      end
      if (idx == eihc_pkg::LEN_BITS'(eihc_pkg::INNER_HI)) begin
         inner_in = {d, inner_in[7:0]};
      end
      if (idx == eihc_pkg::LEN_BITS'(eihc_pkg::INNER_LO)) begin
         inner_in = {inner_in[15:8], d};
      end
      base = tagged_in ? eihc_pkg::LEN_BITS'(eihc_pkg::VLAN_HDR)
                       : eihc_pkg::LEN_BITS'(eihc_pkg::ETH_HDR);
      l4   = base + eihc_pkg::LEN_BITS'({vihl_in[3:0], 2'b00});
      if (idx >= eihc_pkg::LEN_BITS'(eihc_pkg::ETH_HDR)) begin
         if (idx == base) begin
            vihl_in = d;
         end
         if (idx == base + eihc_pkg::LEN_BITS'(2)) begin
            total_in = {d, total_in[7:0]};
         end
         if (idx == base + eihc_pkg::LEN_BITS'(3)) begin
            total_in = {total_in[15:8], d};
         end
         if (idx == base + eihc_pkg::LEN_BITS'(9)) begin
            proto_in = d;
         end
         if (idx > base) begin
            if (idx == l4 + eihc_pkg::LEN_BITS'(4)) begin
               udp_in = {d, udp_in[7:0]};
            end
            if (idx == l4 + eihc_pkg::LEN_BITS'(5)) begin
               udp_in = {udp_in[15:8], d};
            end
         end
      end
   end

   assign push = accept && req_data.last_byte;

   always_comb begin
      push_data.cap           = count_in;
      push_data.wire_len      = req_data.wire_len;
      push_data.ether_kind    = ether_in;
      push_data.inner_kind    = inner_in;
      push_data.version_ihl   = vihl_in;
      push_data.total_length  = total_in;
      push_data.protocol_byte = proto_in;
      push_data.udp_length    = udp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff  <= '0;
         ether_ff  <= '0;
         tagged_ff <= 1'b0;
         inner_ff  <= '0;
         vihl_ff   <= '0;
         total_ff  <= '0;
         proto_ff  <= '0;
         udp_ff    <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         ether_ff  <= ether_in;
         tagged_ff <= tagged_in;
         inner_ff  <= inner_in;
         vihl_ff   <= vihl_in;
         total_ff  <= total_in;
         proto_ff  <= proto_in;
         udp_ff    <= udp_in;
      end
   end

endmodule

// ===== rtl/core/eihc_queue.sv =====
// ---------------------------------------------------------------------------
// eihc_queue: frame summary queue
// Short FIFO between the byte parser and the verdict stage.
// ---------------------------------------------------------------------------
module eihc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  eihc_pkg::summary_type       push_data,
   input  logic                        pop,
   output eihc_pkg::queue_status_type  q_status,
   output eihc_pkg::summary_type       head_data
);

   eihc_pkg::summary_type entry_ff [eihc_pkg::QUEUE_DEPTH];
   logic [eihc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [eihc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [eihc_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign q_status.full     = (count_ff == eihc_pkg::QUEUE_CNT_BITS'(eihc_pkg::QUEUE_DEPTH));
   assign q_status.nonempty = (count_ff != '0);
   assign do_push   = push && !q_status.full;
   assign do_pop    = pop && q_status.nonempty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/eihc_back.sv =====
// ---------------------------------------------------------------------------
// eihc_back: verdict stage
// Evaluates one frame summary and holds the verdict in the output register.
// ---------------------------------------------------------------------------
module eihc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  eihc_pkg::queue_status_type  q_status,
   input  eihc_pkg::summary_type       head_data,
   output logic                        pop,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output eihc_pkg::rsp_type           rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   eihc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [eihc_pkg::CMP_BITS-1:0] cap_c;
      logic [eihc_pkg::CMP_BITS-1:0] wire_c;
      logic [eihc_pkg::CMP_BITS-1:0] room;
      logic [4:0]  base;
      logic [5:0]  hlen;
      logic [6:0]  l4off;
      logic [3:0]  ihl;
      logic [3:0]  ver;
      logic [15:0] total;
      logic [15:0] payload;
      eihc_pkg::status_type  st;
      eihc_pkg::l4_kind_type kind;

      cap_c   = eihc_pkg::CMP_BITS'(head_data.cap);
      wire_c  = eihc_pkg::CMP_BITS'(head_data.wire_len);
      ver     = head_data.version_ihl[7:4];
      ihl     = head_data.version_ihl[3:0];
      total   = head_data.total_length;
      hlen    = {ihl, 2'b00};
      base    = '0;
      st      = eihc_pkg::ST_OK;
      kind    = eihc_pkg::L4_OTHER;

      if (wire_c != cap_c) begin
         st = eihc_pkg::ST_WIRE_MISMATCH;
      end else if (cap_c < eihc_pkg::CMP_BITS'(eihc_pkg::ETH_HDR)) begin
         st = eihc_pkg::ST_TRUNCATED;
      end else if (head_data.ether_kind == eihc_pkg::ETYPE_IPV4) begin
         base = eihc_pkg::ETH_HDR;
      end else if (head_data.ether_kind == eihc_pkg::ETYPE_VLAN) begin
         if (cap_c < eihc_pkg::CMP_BITS'(eihc_pkg::VLAN_HDR)) begin
            st = eihc_pkg::ST_TRUNCATED;
         end else if (head_data.inner_kind != eihc_pkg::ETYPE_IPV4) begin
            st = eihc_pkg::ST_NOT_IPV4;
         end else begin
            base = eihc_pkg::VLAN_HDR;
         end
      end else begin
         st = eihc_pkg::ST_NOT_IPV4;
      end

      room = cap_c - eihc_pkg::CMP_BITS'(base);
      if (st == eihc_pkg::ST_OK) begin
         if (cap_c <= eihc_pkg::CMP_BITS'(base)) begin
            st = eihc_pkg::ST_TRUNCATED;
         end else if (ihl < eihc_pkg::MIN_IHL || ver != eihc_pkg::IP_VERSION) begin
            st = eihc_pkg::ST_BAD_VERSION;
         end else if (eihc_pkg::CMP_BITS'(hlen) > room) begin
            st = eihc_pkg::ST_HDR_BEYOND;
         end else if (eihc_pkg::CMP_BITS'(total) > room) begin
            st = eihc_pkg::ST_TOTAL_BEYOND;
         end
      end

      l4off   = 7'(base) + 7'(hlen);
      payload = total - 16'(hlen);
      if (head_data.protocol_byte == eihc_pkg::PROTO_TCP) begin
         kind = eihc_pkg::L4_TCP;
      end else if (head_data.protocol_byte == eihc_pkg::PROTO_UDP) begin
         if (eihc_pkg::CMP_BITS'(l4off) + eihc_pkg::CMP_BITS'(6) > cap_c) begin
            kind = eihc_pkg::L4_UDP_TRUNC;
         end else if (total >= 16'(hlen) && head_data.udp_length > payload) begin
            kind = eihc_pkg::L4_UDP_BIG;
         end else begin
            kind = eihc_pkg::L4_UDP_OK;
         end
      end

      rsp_data_in.status       = st;
      rsp_data_in.captured_len = cap_c[15:0];
      if (st == eihc_pkg::ST_OK) begin
         rsp_data_in.ip_offset     = base;
         rsp_data_in.ip_header_len = hlen;
         rsp_data_in.ip_total_len  = total;
         rsp_data_in.l4_kind       = kind;
         rsp_data_in.l4_offset     = l4off;
      end else begin
         rsp_data_in.ip_offset     = '0;
         rsp_data_in.ip_header_len = '0;
         rsp_data_in.ip_total_len  = '0;
         rsp_data_in.l4_kind       = eihc_pkg::L4_OTHER;
         rsp_data_in.l4_offset     = '0;
      end
   end

   assign pop          = q_status.nonempty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/core/eth_ipv4_header_checker_top.sv =====
// ---------------------------------------------------------------------------
// eth_ipv4_header_checker_top: Ethernet / 802.1Q / IPv4 header checker
// Takes a frame one byte per transaction and gives one verdict per frame.
//
//   channel   direction  transaction
//   req_*     in         one captured byte, first/last marks, wire length
//   rsp_*     out        one verdict per frame, on the last byte
//
// One byte is taken every cycle while req_stall is low; the parser updates
// its field registers in the cycle a byte arrives. After the last byte the
// frame's summary passes through the summary queue, then the verdict register.
// The four-entry queue raises req_stall only when full; rsp_stall holds the
// verdict register and, once the queue fills, the input.
// Reset clears the parser, the queue and the output valid.
// ---------------------------------------------------------------------------
module eth_ipv4_header_checker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eihc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eihc_pkg::rsp_type rsp_data
);

   eihc_pkg::queue_status_type q_status;
   eihc_pkg::summary_type      push_data;
   eihc_pkg::summary_type      head_data;
   logic                       push;
   logic                       pop;

   eihc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_status  (q_status),
      .req_stall (req_stall),
      .push      (push),
      .push_data (push_data)
   );

   eihc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_status  (q_status),
      .head_data (head_data)
   );

   eihc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/eihc_checker.sv =====
// ---------------------------------------------------------------------------
// eihc_checker: port-level checks for the IPv4 header checker
// Watches the top-level ports and flags broken verdicts or handshakes.
// ---------------------------------------------------------------------------
module eihc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input eihc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input eihc_pkg::rsp_type rsp_data
);

   logic [6:0] l4_sum;
   assign l4_sum = 7'(rsp_data.ip_offset) + 7'(rsp_data.ip_header_len);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("byte changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("verdict changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict valid straight after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != eihc_pkg::ST_OK |->
         rsp_data.ip_offset == '0 && rsp_data.ip_total_len == '0 &&
         rsp_data.l4_kind == eihc_pkg::L4_OTHER && rsp_data.l4_offset == '0)
      else $error("failed frame carries header fields");

   a_ok_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == eihc_pkg::ST_OK |->
         (rsp_data.ip_offset == eihc_pkg::ETH_HDR ||
          rsp_data.ip_offset == eihc_pkg::VLAN_HDR) &&
         rsp_data.l4_offset == l4_sum)
      else $error("bad IP or transport offset");

endmodule

bind eth_ipv4_header_checker_top eihc_checker u_eihc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/eth_ipv4_header_checker_top_test.sv =====
// ---------------------------------------------------------------------------
// eth_ipv4_header_checker_top_test: verdict checks for the IPv4 header checker
// Frames are fed a byte per transaction with random gaps on both channels.
// Every accepted byte updates an independent frame parser, which queues the
// verdict due on each last byte; each verdict from the block is compared
// field by field against the oldest queued one.
// ---------------------------------------------------------------------------
module eth_ipv4_header_checker_top_test;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   eihc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   eihc_pkg::rsp_type rsp_data;

   // frame parser state
   logic [eihc_pkg::LEN_BITS-1:0] byte_count = '0;
   logic [15:0]         ether_kind = '0;
   logic                vlan_tagged = 1'b0;
   logic [15:0]         inner_kind = '0;
   logic [7:0]          version_ihl = '0;
   logic [15:0]         total_length = '0;
   logic [7:0]          protocol_byte = '0;
   logic [15:0]         udp_length = '0;

   eihc_pkg::rsp_type verdict_q[$];
   logic [7:0]  frame_q[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   int          hold_left = 0;
   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;

   eth_ipv4_header_checker_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function void clear_frame_state();
      byte_count = '0;
      ether_kind = '0;
      vlan_tagged = 1'b0;
      inner_kind = '0;
      version_ihl = '0;
      total_length = '0;
      protocol_byte = '0;
      udp_length = '0;
   endfunction

   function void parse_byte(eihc_pkg::req_type r);
      int                    idx, base, cap, hlen, l4, l4off;
      eihc_pkg::status_type  st;
      eihc_pkg::l4_kind_type kind;
      eihc_pkg::rsp_type     v;
      if (r.first_byte) clear_frame_state();
      idx = int'(byte_count);
      if (byte_count != eihc_pkg::LEN_MAX) byte_count = byte_count + 1'b1;
      if (idx == int'(eihc_pkg::ETHTYPE_HI)) ether_kind[15:8] = r.data_byte;
      if (idx == int'(eihc_pkg::ETHTYPE_LO)) begin
         ether_kind[7:0] = r.data_byte;
         vlan_tagged = (ether_kind == eihc_pkg::ETYPE_VLAN);
      end
      if (idx == int'(eihc_pkg::INNER_HI)) inner_kind[15:8] = r.data_byte;
      if (idx == int'(eihc_pkg::INNER_LO)) inner_kind[7:0] = r.data_byte;
      base = vlan_tagged ? int'(eihc_pkg::VLAN_HDR) : int'(eihc_pkg::ETH_HDR);
      if (idx >= int'(eihc_pkg::ETH_HDR)) begin
         if (idx == base) version_ihl = r.data_byte;
         if (idx == base + 2) total_length[15:8] = r.data_byte;
         if (idx == base + 3) total_length[7:0] = r.data_byte;
         if (idx == base + 9) protocol_byte = r.data_byte;
         if (idx > base) begin
            l4 = base + int'(version_ihl[3:0]) * 4;
            if (idx == l4 + 4) udp_length[15:8] = r.data_byte;
            if (idx == l4 + 5) udp_length[7:0] = r.data_byte;
         end
      end
      if (!r.last_byte) return;

      cap = int'(byte_count);
      base = 0;
      hlen = 0;
      l4off = 0;
      st = eihc_pkg::ST_OK;
      kind = eihc_pkg::L4_OTHER;
      if (int'(r.wire_len) != cap) st = eihc_pkg::ST_WIRE_MISMATCH;
      else if (cap < int'(eihc_pkg::ETH_HDR)) st = eihc_pkg::ST_TRUNCATED;
      else if (ether_kind == eihc_pkg::ETYPE_IPV4) base = int'(eihc_pkg::ETH_HDR);
      else if (ether_kind == eihc_pkg::ETYPE_VLAN) begin
         if (cap < int'(eihc_pkg::VLAN_HDR)) st = eihc_pkg::ST_TRUNCATED;
         else if (inner_kind != eihc_pkg::ETYPE_IPV4) st = eihc_pkg::ST_NOT_IPV4;
         else base = int'(eihc_pkg::VLAN_HDR);
      end else st = eihc_pkg::ST_NOT_IPV4;

      if (st == eihc_pkg::ST_OK) begin
         if (cap < base + 1) st = eihc_pkg::ST_TRUNCATED;
         else if (version_ihl[3:0] < eihc_pkg::MIN_IHL ||
                  version_ihl[7:4] != eihc_pkg::IP_VERSION)
            st = eihc_pkg::ST_BAD_VERSION;
         else begin
            hlen = int'(version_ihl[3:0]) * 4;
            if (hlen > cap - base) st = eihc_pkg::ST_HDR_BEYOND;
            else if (int'(total_length) > cap - base) st = eihc_pkg::ST_TOTAL_BEYOND;
         end
      end

      if (st == eihc_pkg::ST_OK) begin
         l4off = base + hlen;
         if (protocol_byte == eihc_pkg::PROTO_TCP) kind = eihc_pkg::L4_TCP;
         else if (protocol_byte == eihc_pkg::PROTO_UDP) begin
            if (l4off + 6 > cap) kind = eihc_pkg::L4_UDP_TRUNC;
            else if (int'(total_length) >= hlen &&
                     int'(udp_length) > int'(total_length) - hlen)
               kind = eihc_pkg::L4_UDP_BIG;
            else kind = eihc_pkg::L4_UDP_OK;
         end
      end else begin
         base = 0;
         hlen = 0;
      end

      v.status = st;
      v.ip_offset = base[4:0];
      v.ip_header_len = hlen[5:0];
      v.ip_total_len = (st == eihc_pkg::ST_OK) ? total_length : 16'd0;
      v.l4_kind = kind;
      v.l4_offset = l4off[6:0];
      v.captured_len = cap[15:0];
      verdict_q.push_back(v);
      clear_frame_state();
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) parse_byte(req_data);
   end

   always @(posedge clock) begin : check_verdicts
      eihc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict with none expected, expected nothing, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = verdict_q.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("ip_offset", want.ip_offset, rsp_data.ip_offset);
            compare_field("ip_header_len", want.ip_header_len, rsp_data.ip_header_len);
            compare_field("ip_total_len", want.ip_total_len, rsp_data.ip_total_len);
            compare_field("l4_kind", want.l4_kind, rsp_data.l4_kind);
            compare_field("l4_offset", want.l4_offset, rsp_data.l4_offset);
            compare_field("captured_len", want.captured_len, rsp_data.captured_len);
         end
      end
   end

   // receiver: random stalls, or a counted hold-off when requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= rsp_idling && ($urandom_range(99) < 35);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic f, input logic l,
                            input logic [15:0] wl);
      eihc_pkg::req_type item;
      item.data_byte = d;
      item.first_byte = f;
      item.last_byte = l;
      item.wire_len = wl;
      while (req_idling && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(input int wire_length, input bit mark_first, input bit mark_last);
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++)
         send_byte(frame_q[i], mark_first && i == 0, mark_last && i == n - 1,
                   (i == n - 1) ? wire_length[15:0] : 16'($urandom));
      bytes_sent += n;
   endtask

   function void put_byte(int pos, logic [7:0] v);
      if (pos < frame_q.size()) frame_q[pos] = v;
   endfunction

   function void fill_frame(logic [7:0] v, int n);
      frame_q.delete();
      repeat (n) frame_q.push_back(v);
   endfunction

   function void build_frame(bit vlan, logic [15:0] etype, logic [7:0] vi, logic [15:0] tot,
                             logic [7:0] proto, logic [15:0] udp_len, int cap_len);
      int base, l4;
      frame_q.delete();
      for (int i = 0; i < cap_len; i++) frame_q.push_back(8'($urandom));
      base = vlan ? int'(eihc_pkg::VLAN_HDR) : int'(eihc_pkg::ETH_HDR);
      l4 = base + int'(vi[3:0]) * 4;
      put_byte(12, vlan ? 8'(eihc_pkg::ETYPE_VLAN >> 8) : etype[15:8]);
      put_byte(13, vlan ? 8'(eihc_pkg::ETYPE_VLAN) : etype[7:0]);
      if (vlan) begin
         put_byte(16, etype[15:8]);
         put_byte(17, etype[7:0]);
      end
      put_byte(base, vi);
      put_byte(base + 2, tot[15:8]);
      put_byte(base + 3, tot[7:0]);
      put_byte(base + 9, proto);
      put_byte(l4 + 4, udp_len[15:8]);
      put_byte(l4 + 5, udp_len[7:0]);
   endfunction

   task automatic run_frame(input bit vlan, input logic [15:0] etype, input logic [7:0] vi,
                            input logic [15:0] tot, input logic [7:0] proto,
                            input logic [15:0] udp_len, input int cap_len, input int wl);
      build_frame(vlan, etype, vi, tot, proto, udp_len, cap_len);
      send_frame(wl, 1'b1, 1'b1);
   endtask

   task automatic test_l4_classes();
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 34, 34);
      run_frame(1, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd28, eihc_pkg::PROTO_UDP, 16'd8, 46, 46);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd28, eihc_pkg::PROTO_UDP, 16'd9, 42, 42);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd25, eihc_pkg::PROTO_UDP, 16'd8, 39, 39);
      // total length below header length: UDP length never fails
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd10, eihc_pkg::PROTO_UDP, 16'hFFFF,
                40, 40);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, 8'hFF, 16'd0, 34, 34);
      run_frame(1, eihc_pkg::ETYPE_IPV4, 8'h4F, 16'd68, eihc_pkg::PROTO_UDP, 16'd8, 86, 86);
   endtask

   task automatic test_header_errors();
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 14, 15);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 14, 0);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 14,
                65535);
      run_frame(0, 16'h86DD, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 14, 14);
      run_frame(1, 16'h86DD, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 18, 18);
      run_frame(1, eihc_pkg::ETYPE_VLAN, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 18, 18);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h65, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 15, 15);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h44, 16'd20, eihc_pkg::PROTO_UDP, 16'd8, 15, 15);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h4F, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 34, 34);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'hFFFF, eihc_pkg::PROTO_TCP, 16'd0,
                34, 34);
   endtask

   task automatic test_short_frames();
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 13, 13);
      run_frame(1, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 17, 17);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 14, 14);
      run_frame(1, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 18, 18);
      // single byte carrying both marks
      fill_frame(8'hFF, 1);
      send_frame(1, 1'b1, 1'b1);
      fill_frame(8'h00, 20);
      send_frame(20, 1'b1, 1'b1);
      fill_frame(8'hFF, 20);
      send_frame(20, 1'b1, 1'b1);
   endtask

   task automatic test_frame_marks();
      // new frame after a verdict without a first mark
      build_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd20, eihc_pkg::PROTO_TCP, 16'd0, 34);
      send_frame(34, 1'b0, 1'b1);
      // first mark in the middle of a frame discards what came before
      build_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd30, eihc_pkg::PROTO_UDP, 16'd10, 10);
      send_frame(0, 1'b1, 1'b0);
      run_frame(0, eihc_pkg::ETYPE_IPV4, 8'h45, 16'd30, eihc_pkg::PROTO_UDP, 16'd10, 44, 44);
   endtask

   task automatic test_receiver_hold();
      req_idling = 1'b0;
      hold_left <= 100;
      repeat (12) begin
         fill_frame(8'($urandom), 1);
         send_frame(1, 1'b1, 1'b1);
      end
      req_idling = 1'b1;
   endtask

   task automatic test_random_frames();
      int          n_frames, pick, ihl, base, payload, cap_len, wl;
      bit          vlan;
      logic [15:0] etype, tot, udp_len;
      logic [7:0]  vi, proto;
      n_frames = 0;
      while (bytes_sent < 800 || n_frames < 5) begin
         // hold a stretch with no idling on either side
         if (n_frames == 1) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         if (n_frames == 4) begin
            req_idling = 1'b1;
            rsp_idling = 1'b1;
         end
         vlan = ($urandom_range(3) == 0);
         pick = $urandom_range(99);
         etype = (pick < 80) ? eihc_pkg::ETYPE_IPV4 :
                 (pick < 88) ? eihc_pkg::ETYPE_VLAN : 16'($urandom);
         ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
         vi = ($urandom_range(9) == 0) ? 8'($urandom) : {eihc_pkg::IP_VERSION, 4'(ihl)};
         ihl = int'(vi[3:0]);
         base = vlan ? int'(eihc_pkg::VLAN_HDR) : int'(eihc_pkg::ETH_HDR);
         payload = $urandom_range(40);
         pick = $urandom_range(99);
         tot = (pick < 70) ? 16'(ihl * 4 + payload) :
               (pick < 85) ? 16'($urandom_range(ihl * 4)) : 16'($urandom);
         pick = $urandom_range(99);
         proto = (pick < 40) ? eihc_pkg::PROTO_TCP :
                 (pick < 85) ? eihc_pkg::PROTO_UDP : 8'($urandom);
         pick = $urandom_range(99);
         udp_len = (pick < 60) ? 16'($urandom_range(payload)) :
                   (pick < 85) ? 16'(payload + $urandom_range(20, 1)) : 16'($urandom);
         cap_len = base + ihl * 4 + payload;
         if ($urandom_range(6) == 0) cap_len = $urandom_range(cap_len, 1);
         wl = ($urandom_range(9) == 0) ? $urandom_range(65535) : cap_len;
         if ($urandom_range(14) == 0) begin
            build_frame(0, 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                        16'($urandom), $urandom_range(30, 1));
            send_frame(0, $urandom_range(1), 1'b0);
            build_frame(vlan, etype, vi, tot, proto, udp_len, cap_len);
            send_frame(wl, 1'b1, 1'b1);
         end else begin
            build_frame(vlan, etype, vi, tot, proto, udp_len, cap_len);
            send_frame(wl, $urandom_range(19) != 0, 1'b1);
         end
         n_frames++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_l4_classes();
      test_header_errors();
      test_short_frames();
      test_frame_marks();
      test_receiver_hold();
      test_random_frames();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/eihc_pkg.sv
rtl/core/eihc_front.sv
rtl/core/eihc_queue.sv
rtl/core/eihc_back.sv
rtl/core/eth_ipv4_header_checker_top.sv
rtl/core/eihc_checker.sv
test/eth_ipv4_header_checker_top_test.sv
